// ===== rtl/sgc_pkg.sv =====
// ----------------------------------------------------------------------------
// sgc_pkg: shared types and constants of the scatter-gather coalescer
// Field widths, the request and result records, and the result push bundle.
// ----------------------------------------------------------------------------
package sgc_pkg;

    localparam int FRAME_W  = 52;
    localparam int OFFSET_W = 12;
    localparam int BYTES_W  = 32;
    localparam int ADDR_W   = 64;
    localparam int LEN_W    = 32;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;

    // Result queue depth; one request pushes at most two results.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_OVERFLOW = 1'b1;

    typedef struct packed {
        logic [FRAME_W-1:0]  page_frame;
        logic [OFFSET_W-1:0] desc_offset;
        logic [BYTES_W-1:0]  desc_bytes;
        logic                first_page;
        logic                last_page;
        logic                list_start;
        logic                list_end;
    } sgc_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  element_address;
        logic [LEN_W-1:0]   element_length;
        logic [INDEX_W-1:0] element_index;
        logic               status;
        logic               list_done;
    } sgc_result_t;

    // Up to two results from one request, in order; b is valid only with a.
    typedef struct packed {
        logic        a_valid;
        logic        b_valid;
        sgc_result_t a;
        sgc_result_t b;
    } sgc_push_t;

endpackage

// ===== rtl/scatter_gather_coalescer.sv =====
// ----------------------------------------------------------------------------
// scatter_gather_coalescer: scatter-gather list coalescing
// Merges per-page descriptor ranges into contiguous list elements.
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  -------   ------------------------   -----------------------------------------
//  item      item_valid / item_stall    page_frame desc_offset desc_bytes
//                                       first_page last_page list_start list_end
//  result    result_valid / result_stall element_address element_length
//                                       element_index status list_done
//  config    cfg_write                  cfg_data (max_elements)
//
//  A request is taken every cycle while the result queue has room for two
//  more results; each request yields zero, one or two results.
//  A request is registered in the input register on accept, then merged and
//  written into the result queue once the queue has room; the queue head
//  drives the result port directly.
//  The result queue (four entries) sets the rate under a stalled output:
//  requests stall once more than two results are waiting.
//  Reset clears the open element, element count, overflow flag and queue;
//  capacity resets to the largest allowed value.
// ----------------------------------------------------------------------------
module scatter_gather_coalescer
    import sgc_pkg::*;
#(
    parameter int PAGE_BITS    = 12,
    parameter int MAX_ELEMENTS = 256
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                item_valid,
    output logic                item_stall,
    input  logic [FRAME_W-1:0]  page_frame,
    input  logic [OFFSET_W-1:0] desc_offset,
    input  logic [BYTES_W-1:0]  desc_bytes,
    input  logic                first_page,
    input  logic                last_page,
    input  logic                list_start,
    input  logic                list_end,

    output logic                result_valid,
    input  logic                result_stall,
    output logic [ADDR_W-1:0]   element_address,
    output logic [LEN_W-1:0]    element_length,
    output logic [INDEX_W-1:0]  element_index,
    output logic                status,
    output logic                list_done,

    input  logic                cfg_write,
    input  logic [COUNT_W-1:0]  cfg_data
);

    // Capacity never exceeds the element index range or the build limit.
    localparam int CAP_LIMIT = (MAX_ELEMENTS < 256) ? MAX_ELEMENTS : 256;
    localparam logic [COUNT_W-1:0] CAP_MAX = COUNT_W'(CAP_LIMIT);

    sgc_item_t          item_reg;
    logic               item_valid_reg, item_valid_next;
    logic [COUNT_W-1:0] cap_reg, cap_next;

    logic               accept;
    logic               fire;
    logic               room;
    logic [ADDR_W-1:0]  start;
    logic [LEN_W-1:0]   len;
    sgc_push_t          push;
    sgc_result_t        out_data;

    // Hold the input register until the merge step can push its results.
    assign fire       = item_valid_reg && room;
    assign item_stall = item_valid_reg && !fire;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
            item_valid_next = 1'b1;
        else if (fire)
            item_valid_next = 1'b0;
    end

    // Clamp the written capacity once, at the write: zero counts as one.
    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_write)
        begin
            priority if (cfg_data == '0)
                cap_next = COUNT_W'(1);
            else if (cfg_data > CAP_MAX)
                cap_next = CAP_MAX;
            else
                cap_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            cap_reg        <= CAP_MAX;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            cap_reg        <= cap_next;
        end
    end

    // Payload capture; no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.page_frame  <= page_frame;
            item_reg.desc_offset <= desc_offset;
            item_reg.desc_bytes  <= desc_bytes;
            item_reg.first_page  <= first_page;
            item_reg.last_page   <= last_page;
            item_reg.list_start  <= list_start;
            item_reg.list_end    <= list_end;
        end
    end

    sgc_page_range #(
        .PAGE_BITS (PAGE_BITS)
    ) u_range (
        .item  (item_reg),
        .start (start),
        .len   (len)
    );

    sgc_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .start (start),
        .len   (len),
        .cap   (cap_reg),
        .push  (push)
    );

    sgc_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (out_data)
    );

    assign element_address = out_data.element_address;
    assign element_length  = out_data.element_length;
    assign element_index   = out_data.element_index;
    assign status          = out_data.status;
    assign list_done       = out_data.list_done;

endmodule

// ===== rtl/sgc_page_range.sv =====
// ----------------------------------------------------------------------------
// sgc_page_range: physical byte range of one page
// Start address and length covered by the descriptor on this page.
// ----------------------------------------------------------------------------
module sgc_page_range
    import sgc_pkg::*;
#(
    parameter int PAGE_BITS = 12
)
(
    input  sgc_item_t          item,
    output logic [ADDR_W-1:0]  start,
    output logic [LEN_W-1:0]   len
);

    localparam logic [OFFSET_W-1:0] OFF_MASK   = OFFSET_W'((64'd1 << PAGE_BITS) - 64'd1);
    localparam logic [LEN_W-1:0]    PAGE_BYTES = LEN_W'(64'd1 << PAGE_BITS);
    localparam logic [LEN_W-1:0]    PAGE_MASK  = PAGE_BYTES - LEN_W'(1);

    logic [OFFSET_W-1:0] off;
    logic [ADDR_W-1:0]   frame_base;
    logic [LEN_W-1:0]    tail_len;

    assign off        = item.desc_offset & OFF_MASK;
    assign frame_base = ADDR_W'({{(ADDR_W-FRAME_W){1'b0}}, item.page_frame} << PAGE_BITS);
    // offset is below the page size, so OR equals add on the zeroed low bits
    assign start      = item.first_page ? (frame_base | ADDR_W'(off)) : frame_base;
    assign tail_len   = (item.desc_bytes + LEN_W'(off)) & PAGE_MASK;

    always_comb
    begin
        unique case ({item.first_page, item.last_page})
            2'b11:   len = item.desc_bytes;
            2'b10:   len = PAGE_BYTES - LEN_W'(off);
            2'b01:   len = (tail_len == '0) ? PAGE_BYTES : tail_len;
            default: len = PAGE_BYTES;
        endcase
    end

endmodule

// ===== rtl/sgc_merge.sv =====
// ----------------------------------------------------------------------------
// sgc_merge: open element state and coalescing decision
// Extend or close the open element, count elements, handle overflow.
// ----------------------------------------------------------------------------
module sgc_merge
    import sgc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  sgc_item_t          item,
    input  logic [ADDR_W-1:0]  start,
    input  logic [LEN_W-1:0]   len,
    input  logic [COUNT_W-1:0] cap,
    output sgc_push_t          push
);

    logic [ADDR_W-1:0]  open_addr_reg, open_addr_next;
    logic [ADDR_W-1:0]  open_end_reg,  open_end_next;
    logic [LEN_W-1:0]   open_len_reg,  open_len_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic               overflowed_reg, overflowed_next;

    logic [COUNT_W-1:0] count_eff;
    logic               drop;
    logic               open_new;
    logic [ADDR_W-1:0]  addr_eff;
    logic [ADDR_W-1:0]  end_eff;
    logic [LEN_W-1:0]   len_eff;
    logic [COUNT_W-1:0] cnt_eff;
    logic [LEN_W:0]     sum;
    logic               extend;
    logic               full;
    sgc_result_t        old_res;
    sgc_result_t        final_res;
    sgc_result_t        ovf_res;

    always_comb
    begin
        count_eff = item.list_start ? '0 : count_reg;
        drop      = !item.list_start && overflowed_reg;
        open_new  = (count_eff == '0);
        addr_eff  = open_new ? start : open_addr_reg;
        end_eff   = open_new ? start : open_end_reg;
        len_eff   = open_new ? '0 : open_len_reg;
        cnt_eff   = open_new ? COUNT_W'(1) : count_eff;
        sum       = {1'b0, len_eff} + {1'b0, len};
        extend    = (end_eff == start) && !sum[LEN_W];
        full      = (cnt_eff >= cap);

        open_addr_next  = open_addr_reg;
        open_end_next   = open_end_reg;
        open_len_next   = open_len_reg;
        count_next      = count_reg;
        overflowed_next = overflowed_reg;

        if (fire && !drop)
        begin
            overflowed_next = 1'b0;
            open_end_next   = start + ADDR_W'(len);
            if (extend)
            begin
                open_addr_next = addr_eff;
                open_len_next  = sum[LEN_W-1:0];
                count_next     = cnt_eff;
            end
            else if (full)
            begin
                overflowed_next = 1'b1;
                count_next      = '0;
            end
            else
            begin
                open_addr_next = start;
                open_len_next  = len;
                count_next     = cnt_eff + COUNT_W'(1);
            end
            if (item.list_end && (extend || !full))
                count_next = '0;
        end

        old_res.element_address = addr_eff;
        old_res.element_length  = len_eff;
        old_res.element_index   = INDEX_W'(cnt_eff - COUNT_W'(1));
        old_res.status          = STATUS_OK;
        old_res.list_done       = 1'b0;

        final_res.element_address = extend ? addr_eff : start;
        final_res.element_length  = extend ? sum[LEN_W-1:0] : len;
        final_res.element_index   = extend ? INDEX_W'(cnt_eff - COUNT_W'(1))
                                           : INDEX_W'(cnt_eff);
        final_res.status          = STATUS_OK;
        final_res.list_done       = 1'b1;

        ovf_res.element_address = '0;
        ovf_res.element_length  = '0;
        ovf_res.element_index   = '0;
        ovf_res.status          = STATUS_OVERFLOW;
        ovf_res.list_done       = 1'b1;

        if (extend)
        begin
            push.a_valid = fire && !drop && item.list_end;
            push.b_valid = 1'b0;
            push.a       = final_res;
            push.b       = final_res;
        end
        else
        begin
            push.a_valid = fire && !drop;
            push.b_valid = fire && !drop && (full || item.list_end);
            push.a       = old_res;
            push.b       = full ? ovf_res : final_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_addr_reg  <= '0;
            open_end_reg   <= '0;
            open_len_reg   <= '0;
            count_reg      <= '0;
            overflowed_reg <= 1'b0;
        end
        else
        begin
            open_addr_reg  <= open_addr_next;
            open_end_reg   <= open_end_next;
            open_len_reg   <= open_len_next;
            count_reg      <= count_next;
            overflowed_reg <= overflowed_next;
        end
    end

endmodule

// ===== rtl/sgc_result_queue.sv =====
// ----------------------------------------------------------------------------
// sgc_result_queue: small result FIFO
// Take up to two results per cycle, deliver one per handshake.
// ----------------------------------------------------------------------------
module sgc_result_queue
    import sgc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sgc_push_t   push,
    output logic        room,
    output logic        out_valid,
    input  logic        out_stall,
    output sgc_result_t out_data
);

    sgc_result_t       entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg,  cnt_next;
    logic [QPTR_W-1:0] wptr_b;
    logic [QCNT_W-1:0] push_n;
    logic              pop;

    assign room      = (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = entry_reg[rptr_reg];
    assign pop       = out_valid && !out_stall;
    assign push_n    = QCNT_W'(push.a_valid) + QCNT_W'(push.b_valid);
    assign wptr_b    = wptr_reg + QPTR_W'(1);
    assign wptr_next = wptr_reg + QPTR_W'(push_n);
    assign rptr_next = rptr_reg + QPTR_W'(pop);
    assign cnt_next  = cnt_reg + push_n - QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.a_valid)
            entry_reg[wptr_reg] <= push.a;
        if (push.b_valid)
            entry_reg[wptr_b] <= push.b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule
